// File: rtl/mtrig_pkg.sv
// ----------------------------------------------------------------------------
// mtrig_pkg
// Shared types, field widths and register codes of the multiplicity trigger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtrig_pkg;

  // Default sizes of the channel, window and bucket stores
  localparam int CHANNELS_DEF   = 1024;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int BUCKETS_DEF    = 512;

  // Field widths
  localparam int CH_W    = 10;
  localparam int ADC_W   = 12;
  localparam int PW_W    = 4;
  localparam int PH_W    = 8;
  localparam int WL_W    = 9;
  localparam int SF_W    = 4;
  localparam int MULT_W  = 30;
  localparam int IDX_W   = 9;
  localparam int SUM_W   = 18;
  localparam int TOTAL_W = 26;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Register reset values
  localparam logic [ADC_W-1:0]  PAD_THR_RST  = 12'd0;
  localparam logic [PW_W-1:0]   PULSE_W_RST  = 4'd2;
  localparam logic [PH_W-1:0]   PULSE_H_RST  = 8'd48;
  localparam logic [WL_W-1:0]   WIN_LEN_RST  = 9'd150;
  localparam logic [SF_W-1:0]   SCALE_RST    = 4'd2;
  localparam logic [MULT_W-1:0] MULT_THR_RST = 30'd14000;

  // Register index codes (byte address / 4)
  typedef enum logic [2:0] {
    REG_PAD_THR  = 3'd0,
    REG_PULSE_W  = 3'd1,
    REG_PULSE_H  = 3'd2,
    REG_WIN_LEN  = 3'd3,
    REG_SCALE    = 3'd4,
    REG_MULT_THR = 3'd5
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [ADC_W-1:0]  fire_level;
    logic [PW_W-1:0]   pulse_width;
    logic [PH_W-1:0]   pulse_height;
    logic [WL_W-1:0]   window_length;
    logic [SF_W-1:0]   scale_factor;
    logic [MULT_W-1:0] trig_level;
  } cfg_t;

  // Clearing sequencer states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } st_t;

endpackage

`default_nettype wire

// File: rtl/multiplicity_trigger.sv
// ----------------------------------------------------------------------------
// Multiplicity trigger
// Sliding-window multiplicity trigger over a stream of channel ADC samples.
// ----------------------------------------------------------------------------
//   channel   dir  fields (lowest bit first)
//   s_axis    in   tdata: channel[9:0] adc_sample[21:10]; tlast: bucket_end;
//                  tuser: event_start
//   m_axis    out  tdata: bucket_index[8:0] multiplicity[38:9];
//                  tuser: above_threshold[0] event_triggered[1]
//   apb       in   six registers at byte address 4*i, pready tied high
//
// One item per cycle outside clearing passes and output stalls. A result is
// captured in the output register when its closing item leaves the input
// stage. Reset and every accepted event_start item start a clearing pass
// over the pulse and history memories, sweeping max(CHANNELS, WINDOW_MAX)
// addresses (1024 by default); s_tready is low during it.
// A stalled m_tready holds the output register; other items still pass, but
// the next bucket_end item then waits in the input stage and s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiplicity_trigger #(
  parameter int CHANNELS   = mtrig_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX = mtrig_pkg::WINDOW_MAX_DEF,
  parameter int BUCKETS    = mtrig_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // channel[9:0], adc_sample[21:10], zero pad
  input  wire logic        s_tlast,   // bucket_end
  input  wire logic [0:0]  s_tuser,   // event_start[0]
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // bucket_index[8:0], multiplicity[38:9], zero pad
  output logic      [1:0]  m_tuser,   // above_threshold[0], event_triggered[1]
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mtrig_pkg::*;

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WM_AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int BK_W    = $clog2(BUCKETS);
  localparam int SWEEP_N = (CHANNELS > WINDOW_MAX) ? CHANNELS : WINDOW_MAX;
  localparam int SWP_W   = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;
  localparam logic [BK_W-1:0]  BK_TOP   = BK_W'(BUCKETS - 1);
  localparam logic [SWP_W-1:0] SWP_LAST = SWP_W'(SWEEP_N - 1);

  cfg_t             cfg;
  logic [WL_W-1:0]  wl_next;

  // Clearing sequencer
  st_t              state;
  st_t              st_next;
  logic [SWP_W-1:0] sweep_cnt;
  logic [31:0]      sweep_wide;
  logic             sweep_last;
  logic             clearing;
  logic             running;

  // Input stage
  logic             s_accept;
  logic             s1_valid;
  logic [CH_W-1:0]  s1_ch;
  logic [ADC_W-1:0] s1_adc;
  logic             s1_bend;
  logic             s1_estart;
  logic             s1_fire;
  logic [31:0]      in_ch_wide;
  logic [31:0]      s1_ch_wide;
  logic [PW_W-1:0]  pulse_rd;

  // Channel and bucket arithmetic
  logic             in_range;
  logic             active;
  logic [PW_W-1:0]  p_eff;
  logic [PW_W-1:0]  p_new;
  logic [SUM_W-1:0] old_raw;
  logic [SUM_W-1:0] old_eff;
  logic [SUM_W-1:0] bucket_sum;
  logic [SUM_W-1:0] bs_eff;
  logic [SUM_W:0]   bs_add;
  logic [SUM_W-1:0] bs_new;
  logic [TOTAL_W-1:0] window_total;
  logic [TOTAL_W-1:0] wt_eff;
  logic [TOTAL_W-1:0] wt_sub;
  logic [TOTAL_W:0]   wt_add;
  logic [TOTAL_W-1:0] wt_new;
  logic [BK_W-1:0]  bucket_counter;
  logic [BK_W-1:0]  bk_eff;
  logic [BK_W-1:0]  bk_new;
  logic [31:0]      bk_wide;
  logic             trigger_latch;
  logic             latch_eff;
  logic [MULT_W-1:0] mult;
  logic             above;

  // Output register
  logic             o_valid;
  logic [IDX_W-1:0] o_idx;
  logic [MULT_W-1:0] o_mult;
  logic             o_above;
  logic             o_trig;

  // Pulse memory ports
  logic             pm_we;
  logic [CH_AW-1:0] pm_waddr;
  logic [PW_W-1:0]  pm_wdata;

  mtrig_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .wl_next (wl_next)
  );

  // Handshakes
  assign s_accept = s_tvalid && s_tready;
  assign s1_fire  = s1_valid && running && (!s1_bend || !o_valid || m_tready);
  assign s_tready = running && (!s1_valid || s1_fire);

  // Sequencer: next state
  always_comb begin
    st_next = state;
    unique case (state)
      ST_CLEAR: if (sweep_last) st_next = ST_RUN;
      ST_RUN:   if (s_accept && s_tuser[0]) st_next = ST_CLEAR;
      default:  st_next = ST_CLEAR;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    clearing = 1'b0;
    running  = 1'b0;
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   running  = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_cnt <= '0;
    end else begin
      state     <= st_next;
      sweep_cnt <= clearing ? sweep_cnt + 1'b1 : '0;
    end
  end

  assign sweep_last = (sweep_cnt == SWP_LAST);
  assign sweep_wide = 32'(sweep_cnt);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_ch     <= s_tdata[CH_W-1:0];
      s1_adc    <= s_tdata[CH_W+ADC_W-1:CH_W];
      s1_bend   <= s_tlast;
      s1_estart <= s_tuser[0];
    end
  end

  assign in_ch_wide = 32'(s_tdata[CH_W-1:0]);
  assign s1_ch_wide = 32'(s1_ch);

  // Channel pulse memory: cleared by the sweep, updated as each item retires
  assign pm_we    = clearing ? (sweep_wide < 32'(CHANNELS)) : (s1_fire && in_range);
  assign pm_waddr = clearing ? sweep_wide[CH_AW-1:0] : s1_ch_wide[CH_AW-1:0];
  assign pm_wdata = clearing ? '0 : p_new;

  mtrig_ram #(
    .DEPTH (CHANNELS),
    .AW    (CH_AW),
    .DW    (PW_W)
  ) u_pulse (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .re    (s_accept),
    .raddr (in_ch_wide[CH_AW-1:0]),
    .rdata (pulse_rd)
  );

  mtrig_window #(
    .WINDOW_MAX (WINDOW_MAX),
    .WM_AW      (WM_AW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .wl_next    (wl_next),
    .sweep_we   (clearing && (sweep_wide < 32'(WINDOW_MAX))),
    .sweep_addr (sweep_wide[WM_AW-1:0]),
    .push       (s1_fire && s1_bend),
    .restart    (s1_fire && s1_estart),
    .push_data  (bs_new),
    .old_sum    (old_raw)
  );

  // Event start drops all state ahead of this item
  assign p_eff     = s1_estart ? '0 : pulse_rd;
  assign old_eff   = s1_estart ? '0 : old_raw;
  assign bs_eff    = s1_estart ? '0 : bucket_sum;
  assign wt_eff    = s1_estart ? '0 : window_total;
  assign bk_eff    = s1_estart ? '0 : bucket_counter;
  assign latch_eff = s1_estart ? 1'b0 : trigger_latch;

  // Discriminator: run an existing pulse down, or fire on a sample above threshold
  assign in_range = (s1_ch_wide < 32'(CHANNELS));
  always_comb begin
    active = 1'b0;
    p_new  = '0;
    if (in_range) begin
      if (p_eff != '0) begin
        p_new  = p_eff - 1'b1;
        active = 1'b1;
      end else if (s1_adc > cfg.fire_level) begin
        p_new  = (cfg.pulse_width == '0) ? '0 : cfg.pulse_width - 1'b1;
        active = 1'b1;
      end
    end
  end

  // Bucket sum, saturating
  assign bs_add = {1'b0, bs_eff} + (SUM_W+1)'(cfg.pulse_height);
  always_comb begin
    bs_new = bs_eff;
    if (active) begin
      bs_new = bs_add[SUM_W] ? SUM_MAX : bs_add[SUM_W-1:0];
    end
  end

  // Multiplicity of the closing bucket; the product always fits in 30 bits
  assign mult  = MULT_W'(wt_eff) * MULT_W'(cfg.scale_factor);
  assign above = (mult > cfg.trig_level);

  // Slide the window: drop the expiring bucket, add the closed one
  assign wt_sub = (wt_eff > TOTAL_W'(old_eff)) ? wt_eff - TOTAL_W'(old_eff) : '0;
  assign wt_add = {1'b0, wt_sub} + (TOTAL_W+1)'(bs_new);
  assign wt_new = wt_add[TOTAL_W] ? TOTAL_MAX : wt_add[TOTAL_W-1:0];

  assign bk_new  = (bk_eff == BK_TOP) ? '0 : bk_eff + 1'b1;
  assign bk_wide = 32'(bk_eff);

  // Running state
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_sum     <= '0;
      window_total   <= '0;
      bucket_counter <= '0;
      trigger_latch  <= 1'b0;
    end else if (s1_fire) begin
      bucket_sum     <= s1_bend ? '0 : bs_new;
      window_total   <= s1_bend ? wt_new : wt_eff;
      bucket_counter <= s1_bend ? bk_new : bk_eff;
      trigger_latch  <= latch_eff || (s1_bend && above);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire && s1_bend) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_bend) begin
      o_idx   <= bk_wide[IDX_W-1:0];
      o_mult  <= mult;
      o_above <= above;
      o_trig  <= latch_eff || above;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_mult, o_idx};
  assign m_tuser  = {o_trig, o_above};

endmodule

`default_nettype wire

// File: rtl/mtrig_cfg.sv
// ----------------------------------------------------------------------------
// mtrig_cfg
// APB register file holding the trigger configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrig_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [4:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output mtrig_pkg::cfg_t                cfg,
  output logic [mtrig_pkg::WL_W-1:0]     wl_next
);
  import mtrig_pkg::*;

  cfg_t     cfg_next;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  // Decode a write into the register set
  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      unique case (idx)
        REG_PAD_THR:  cfg_next.fire_level    = pwdata[ADC_W-1:0];
        REG_PULSE_W:  cfg_next.pulse_width   = pwdata[PW_W-1:0];
        REG_PULSE_H:  cfg_next.pulse_height  = pwdata[PH_W-1:0];
        REG_WIN_LEN:  cfg_next.window_length = pwdata[WL_W-1:0];
        REG_SCALE:    cfg_next.scale_factor  = pwdata[SF_W-1:0];
        REG_MULT_THR: cfg_next.trig_level    = pwdata[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  assign wl_next = cfg_next.window_length;

  // Hold the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fire_level    <= PAD_THR_RST;
      cfg.pulse_width   <= PULSE_W_RST;
      cfg.pulse_height  <= PULSE_H_RST;
      cfg.window_length <= WIN_LEN_RST;
      cfg.scale_factor  <= SCALE_RST;
      cfg.trig_level    <= MULT_THR_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_PAD_THR:  prdata = 32'(cfg.fire_level);
      REG_PULSE_W:  prdata = 32'(cfg.pulse_width);
      REG_PULSE_H:  prdata = 32'(cfg.pulse_height);
      REG_WIN_LEN:  prdata = 32'(cfg.window_length);
      REG_SCALE:    prdata = 32'(cfg.scale_factor);
      REG_MULT_THR: prdata = 32'(cfg.trig_level);
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mtrig_ram.sv
// ----------------------------------------------------------------------------
// mtrig_ram
// Single write, single read memory with registered read and write bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrig_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: a write to the same address at this edge is passed through
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtrig_window.sv
// ----------------------------------------------------------------------------
// mtrig_window
// Bucket sum history: write pointer, expiring-bucket address and prefetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrig_window #(
  parameter int WINDOW_MAX = 256,
  parameter int WM_AW      = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [mtrig_pkg::WL_W-1:0]   wl_next,
  input  wire logic                         sweep_we,
  input  wire logic [WM_AW-1:0]             sweep_addr,
  input  wire logic                         push,
  input  wire logic                         restart,
  input  wire logic [mtrig_pkg::SUM_W-1:0]  push_data,
  output logic      [mtrig_pkg::SUM_W-1:0]  old_sum
);
  import mtrig_pkg::*;

  localparam int SW_RAW = $clog2(2 * WINDOW_MAX + 1);
  localparam int SW     = (SW_RAW > WL_W + 1) ? SW_RAW : WL_W + 1;
  localparam logic [SW-1:0]    WM_S   = SW'(WINDOW_MAX);
  localparam logic [WM_AW-1:0] PTR_TOP = WM_AW'(WINDOW_MAX - 1);

  logic [WM_AW-1:0] ptr;
  logic [WM_AW-1:0] ptr_eff;
  logic [WM_AW-1:0] ptr_next;
  logic [SW-1:0]    len;
  logic [SW-1:0]    back_pos;
  logic [SW-1:0]    rd_pos;
  logic             we;
  logic [WM_AW-1:0] waddr;
  logic [SUM_W-1:0] wdata;

  // Advance the write pointer once per closed bucket; an event start zeroes it
  assign ptr_eff = restart ? '0 : ptr;
  always_comb begin
    ptr_next = ptr_eff;
    if (push) begin
      ptr_next = (ptr_eff == PTR_TOP) ? '0 : ptr_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    len = SW'(wl_next);
    if (len == '0) begin
      len = SW'(1);
    end else if (len > WM_S) begin
      len = WM_S;
    end
  end

  // Slot of the bucket that leaves the window: (ptr_next - len) mod WINDOW_MAX
  assign back_pos = SW'(ptr_next) + WM_S - len;
  assign rd_pos   = (back_pos >= WM_S) ? back_pos - WM_S : back_pos;

  assign we    = sweep_we || push;
  assign waddr = sweep_we ? sweep_addr : ptr_eff;
  assign wdata = sweep_we ? '0 : push_data;

  mtrig_ram #(
    .DEPTH (WINDOW_MAX),
    .AW    (WM_AW),
    .DW    (SUM_W)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (1'b1),
    .raddr (rd_pos[WM_AW-1:0]),
    .rdata (old_sum)
  );

endmodule

`default_nettype wire

// File: rtl/mtrig_checker.sv
// ----------------------------------------------------------------------------
// mtrig_checker
// Port-level checks of the multiplicity trigger, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtrig_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A bucket above threshold always sets the sticky event flag
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("above_threshold without event_triggered");

  // Reset starts the clearing pass, so no item is taken next cycle
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input ready or result valid right after reset");

  // An accepted event start holds off the next item for the clearing pass
  a_evt_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input ready right after event start");

endmodule

bind multiplicity_trigger mtrig_checker u_mtrig_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
